### design/mcck_pkg.sv
// Package: shared widths, defaults and controller states for the min-cost cover solver.
package mcck_pkg;

  localparam int COST_W      = 30;
  localparam int ITEM_COST_W = 16;
  localparam int VOL_W       = 14;
  localparam int DIST_OUT_W  = 8;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam int MAX_ITEMS_DEF   = 128;
  localparam int TABLE_DEPTH_DEF = 16384;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_FETCH,
    S_ROW,
    S_TAIL
  } state_t;

endpackage

### design/mcck_ifs.sv
// Channel interfaces: item input, result output and target configuration.
interface mcck_in_if;
  logic                               valid;
  logic                               ready;
  logic [mcck_pkg::ITEM_COST_W-1:0]   item_cost;
  logic [mcck_pkg::VOL_W-1:0]         item_volume;
  logic                               last_item;

  modport source (output valid, item_cost, item_volume, last_item, input ready);
  modport sink   (input valid, item_cost, item_volume, last_item, output ready);
endinterface

interface mcck_out_if;
  logic                               valid;
  logic                               ready;
  logic [mcck_pkg::COST_W-1:0]        min_cost;
  logic [mcck_pkg::DIST_OUT_W-1:0]    distinct_count;
  logic                               overflow;

  modport source (output valid, min_cost, distinct_count, overflow, input ready);
  modport sink   (input valid, min_cost, distinct_count, overflow, output ready);
endinterface

interface mcck_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mcck_pkg::VOL_W-1:0]         target_volume;

  modport source (output valid, target_volume, input ready);
  modport sink   (input valid, target_volume, output ready);
endinterface

### design/min_cost_cover_knapsack.sv
// Top level: item store, two-row DP table in RAM and the row/volume sequencer.
//
//  channel | dir | fields                                   | handshake
//  in_ch   | in  | item_cost, item_volume, last_item        | valid/ready
//  out_ch  | out | min_cost, distinct_count, overflow       | valid/ready
//  cfg_ch  | in  | target_volume                            | valid/ready
//
// Items load at one per cycle while the controller is in its load state. The
// solve computes one table entry per cycle within a row, as a read-modify-write
// through the two row RAMs. A target of 0 is answered without a table pass.
// Reset clears control only; no table clearing pass is needed.
// After a closing item the solve waits until any earlier result has been taken.
module min_cost_cover_knapsack #(
  parameter int MAX_ITEMS   = mcck_pkg::MAX_ITEMS_DEF,
  parameter int TABLE_DEPTH = mcck_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mcck_in_if.sink     in_ch,
  mcck_out_if.source  out_ch,
  mcck_cfg_if.sink    cfg_ch
);

  localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int DW  = $clog2(MAX_ITEMS + 1);
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int VW  = mcck_pkg::VOL_W;
  localparam int KW  = (AW > VW) ? AW : VW;
  localparam int CSW = mcck_pkg::COST_W;
  localparam int ICW = mcck_pkg::ITEM_COST_W;
  localparam int EW  = CSW + DW + 1;
  localparam int IMW = ICW + VW;

  localparam logic [KW-1:0] K_MAX   = KW'(TABLE_DEPTH - 1);
  localparam logic [IW-1:0] ROW_MAX = IW'(MAX_ITEMS - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);

  typedef struct packed {
    logic [CSW-1:0] cost;
    logic [DW-1:0]  ntypes;
    logic           took;
  } entry_t;

  mcck_pkg::state_t state_r, state_nxt;

  logic [VW-1:0]  target_r;
  logic [CW-1:0]  total_r;
  logic           drop_r;
  logic           solve_drop_r;
  logic [IW-1:0]  row_r;
  logic           first_row_r;
  logic [AW-1:0]  tgt_r;
  logic [AW-1:0]  k_r;
  logic [ICW-1:0] c_r;
  logic [VW-1:0]  v_r;

  logic           s1_valid_r;
  logic [AW-1:0]  s1_k_r;
  logic           s1_zero_r;
  logic           s1_use_a_r;
  logic           fwd_r;
  entry_t         fwd_data_r;

  logic [CSW-1:0]        out_cost_r;
  logic [DW-1:0]         out_dist_r;
  logic                  out_ovf_r;
  logic                  out_valid_r;

  logic           in_acc;
  logic           in_ready;
  logic           out_free;
  logic           issue;
  logic           start_go;
  logic           tail_more;
  logic [IW-1:0]  item_raddr;
  logic [IMW-1:0] item_rdata;
  logic           item_we;

  logic [AW-1:0]  tgt_clamp;
  logic           k_ge_v;
  logic           use_a;
  logic [AW-1:0]  kp;

  logic [EW-1:0]  rd0, rd1;
  entry_t         cur_e, nxt_e, a_e, wdata;
  logic [CSW:0]   re1_sum;
  logic [CSW-1:0] re1;
  logic [DW-1:0]  num1;
  logic           wr_last;

  // controller
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcck_pkg::S_LOAD:  if (in_acc && in_ch.last_item) state_nxt = mcck_pkg::S_START;
      mcck_pkg::S_START: if (out_free) begin
        state_nxt = (tgt_clamp == '0) ? mcck_pkg::S_LOAD : mcck_pkg::S_FETCH;
      end
      mcck_pkg::S_FETCH: state_nxt = mcck_pkg::S_ROW;
      mcck_pkg::S_ROW:   if (k_r == tgt_r) state_nxt = mcck_pkg::S_TAIL;
      mcck_pkg::S_TAIL:  state_nxt = (row_r == '0) ? mcck_pkg::S_LOAD : mcck_pkg::S_FETCH;
      default:           state_nxt = mcck_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    issue      = 1'b0;
    start_go   = 1'b0;
    tail_more  = 1'b0;
    item_raddr = row_r;
    unique case (state_r)
      mcck_pkg::S_LOAD:  in_ready = 1'b1;
      mcck_pkg::S_START: start_go = out_free;
      mcck_pkg::S_FETCH: item_raddr = row_r;
      mcck_pkg::S_ROW:   issue = 1'b1;
      mcck_pkg::S_TAIL:  begin
        tail_more  = (row_r != '0);
        item_raddr = row_r - 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign in_ch.ready  = in_ready;
  assign in_acc       = in_ch.valid && in_ready;
  assign out_free     = !out_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign item_we      = in_acc && (total_r < CNT_MAX);

  assign tgt_clamp = (KW'(target_r) > K_MAX) ? AW'(K_MAX) : AW'(target_r);

  // stage 0: address generation
  assign k_ge_v = (KW'(k_r) >= KW'(v_r));
  assign use_a  = k_ge_v && (k_r != '0);
  assign kp     = AW'(KW'(k_r) - KW'(v_r));

  mcck_ram #(.W(IMW), .DEPTH(MAX_ITEMS)) u_items (
    .clk   (clk),
    .we    (item_we),
    .waddr (total_r[IW-1:0]),
    .wdata ({in_ch.item_cost, in_ch.item_volume}),
    .raddr (item_raddr),
    .rdata (item_rdata)
  );

  mcck_ram #(.W(EW), .DEPTH(TABLE_DEPTH)) u_row0 (
    .clk   (clk),
    .we    (s1_valid_r && !row_r[0]),
    .waddr (s1_k_r),
    .wdata (wdata),
    .raddr (row_r[0] ? k_r : kp),
    .rdata (rd0)
  );

  mcck_ram #(.W(EW), .DEPTH(TABLE_DEPTH)) u_row1 (
    .clk   (clk),
    .we    (s1_valid_r && row_r[0]),
    .waddr (s1_k_r),
    .wdata (wdata),
    .raddr (row_r[0] ? kp : k_r),
    .rdata (rd1)
  );

  // stage 1: combine
  assign cur_e = row_r[0] ? entry_t'(rd1) : entry_t'(rd0);
  assign nxt_e = row_r[0] ? entry_t'(rd0) : entry_t'(rd1);

  always_comb begin
    a_e = '0;
    if (s1_use_a_r) begin
      a_e = fwd_r ? fwd_data_r : cur_e;
    end
  end

  assign re1_sum = {1'b0, a_e.cost} + (CSW + 1)'(c_r);
  assign re1     = re1_sum[CSW] ? mcck_pkg::COST_MAX : re1_sum[CSW-1:0];
  assign num1    = a_e.ntypes + DW'(!a_e.took);

  always_comb begin
    priority if (s1_zero_r) begin
      wdata = '0;
    end else if (first_row_r || re1 < nxt_e.cost) begin
      wdata = '{cost: re1, ntypes: num1, took: 1'b1};
    end else if (re1 > nxt_e.cost) begin
      wdata = '{cost: nxt_e.cost, ntypes: nxt_e.ntypes, took: 1'b0};
    end else begin
      wdata = '{cost: re1, ntypes: (num1 > nxt_e.ntypes) ? num1 : nxt_e.ntypes,
                took: (num1 > nxt_e.ntypes)};
    end
  end

  assign wr_last = s1_valid_r && (row_r == '0) && (s1_k_r == tgt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcck_pkg::S_LOAD;
      target_r    <= '0;
      total_r     <= '0;
      drop_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= issue;
      if (cfg_ch.valid) begin
        target_r <= cfg_ch.target_volume;
      end
      if (in_acc) begin
        if (in_ch.last_item) begin
          total_r <= '0;
          drop_r  <= 1'b0;
        end else if (total_r < CNT_MAX) begin
          total_r <= total_r + 1'b1;
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end else if ((start_go && tgt_clamp == '0) || wr_last) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last_item) begin
      solve_drop_r <= drop_r || (total_r >= CNT_MAX);
      row_r        <= (total_r < CNT_MAX) ? total_r[IW-1:0] : ROW_MAX;
      first_row_r  <= 1'b1;
    end
    if (start_go) begin
      tgt_r <= tgt_clamp;
    end
    if (tail_more) begin
      row_r       <= row_r - 1'b1;
      first_row_r <= 1'b0;
    end
    if (state_r == mcck_pkg::S_FETCH) begin
      c_r <= item_rdata[IMW-1:VW];
      v_r <= (item_rdata[VW-1:0] == '0) ? VW'(1) : item_rdata[VW-1:0];
      k_r <= '0;
    end else if (issue) begin
      k_r <= k_r + 1'b1;
    end
    s1_k_r     <= k_r;
    s1_zero_r  <= (k_r == '0);
    s1_use_a_r <= use_a;
    fwd_r      <= use_a && s1_valid_r && (kp == s1_k_r);
    fwd_data_r <= wdata;
    if (start_go && tgt_clamp == '0) begin
      out_cost_r <= '0;
      out_dist_r <= '0;
      out_ovf_r  <= solve_drop_r;
    end else if (wr_last) begin
      out_cost_r <= wdata.cost;
      out_dist_r <= wdata.ntypes;
      out_ovf_r  <= solve_drop_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.min_cost       = out_cost_r;
  assign out_ch.distinct_count = mcck_pkg::DIST_OUT_W'(out_dist_r);
  assign out_ch.overflow       = out_ovf_r;

  a_s1_from_row: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(state_r == mcck_pkg::S_ROW))
    else $error("combine stage active without a preceding issue cycle");

  a_solve_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcck_pkg::S_FETCH) |-> !out_valid_r)
    else $error("solve running while a result is still pending");

  a_fwd_unit_vol: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && fwd_r) |-> (v_r == VW'(1)))
    else $error("forwarding taken for a volume other than one");

  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.ready && !$past(in_ch.ready)) |-> (state_r == mcck_pkg::S_LOAD && !s1_valid_r))
    else $error("input reopened before the table pass drained");

endmodule

### design/mcck_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcck_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
